/* rtl/htpr_pkg.sv */
// Shared types and register constants of the haze transmission pixel recovery block.
`timescale 1ns / 1ps
package htpr_pkg;

   localparam int CsrAddrWidth = 5;
   localparam int CsrIndexWidth = 3;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_AIRLIGHT_BLUE  = 3'd0,
      CSR_AIRLIGHT_GREEN = 3'd1,
      CSR_AIRLIGHT_RED   = 3'd2,
      CSR_OMEGA_BLUE     = 3'd3,
      CSR_OMEGA_GREEN    = 3'd4,
      CSR_OMEGA_RED      = 3'd5,
      CSR_TRANS_FLOOR    = 3'd6,
      CSR_UNUSED         = 3'd7
   } csr_index_type;

   localparam logic [7:0]  AirlightReset = 8'd220;
   localparam logic [15:0] OmegaReset    = 16'd52429;
   localparam logic [15:0] FloorReset    = 16'd6554;

   typedef struct packed {
      logic [7:0]  airlight;
      logic [15:0] omega;
      logic [15:0] trans_floor;
   } chan_cfg_type;

endpackage

/* rtl/htpr_div_cell.sv */
// One restoring division cell: resolves one quotient bit and passes the rest on.
`timescale 1ns / 1ps
module htpr_div_cell #(
   parameter int NW = 24,
   parameter int VW = 8,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          en,
   input  logic [VW-1:0] rem_i,
   input  logic [NW-1:0] num_i,
   input  logic [VW-1:0] den_i,
   input  logic [PW-1:0] pay_i,
   output logic [VW-1:0] rem_o,
   output logic [NW-1:0] num_o,
   output logic [VW-1:0] den_o,
   output logic [PW-1:0] pay_o
);

   logic [VW:0]   trial;
   logic          ge;
   logic [VW-1:0] rem_in;
   logic [NW-1:0] num_in;
   logic [VW:0]   diff;
   logic [VW-1:0] rem_ff;
   logic [NW-1:0] num_ff;
   logic [VW-1:0] den_ff;
   logic [PW-1:0] pay_ff;

   always_comb begin
      trial  = {rem_i, num_i[NW-1]};
      diff   = trial - {1'b0, den_i};
      ge     = trial >= {1'b0, den_i};
      rem_in = ge ? diff[VW-1:0] : trial[VW-1:0];
      num_in = {num_i[NW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_i;
         pay_ff <= pay_i;
      end
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign den_o = den_ff;
   assign pay_o = pay_ff;

endmodule

/* rtl/htpr_chan.sv */
// One color channel: transmission divider chain, recovery divider chain, rounding.
`timescale 1ns / 1ps
module htpr_chan #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  htpr_pkg::chan_cfg_type cfg,
   input  logic [7:0]            pix_i,
   output logic [7:0]            pix_o
);

   localparam int F  = FRAC_BITS;
   localparam int NW = F + 8;
   localparam int TW = F + 1;
   localparam logic [TW-1:0] One = {1'b1, {F{1'b0}}};

   logic [F-1:0] om;
   logic [F-1:0] fl_raw;
   logic [F-1:0] fl;
   logic [7:0]   a;

   generate
      if (F >= 16) begin : g_shl
         assign om     = F'(cfg.omega) << (F - 16);
         assign fl_raw = F'(cfg.trans_floor) << (F - 16);
      end else begin : g_shr
         assign om     = cfg.omega[15 -: F];
         assign fl_raw = cfg.trans_floor[15 -: F];
      end
   endgenerate

   assign fl = (fl_raw == '0) ? F'(1) : fl_raw;
   assign a  = (cfg.airlight == 8'd0) ? 8'd1 : cfg.airlight;

   logic [NW-1:0] prod_ff;
   logic [7:0]    a_ff;
   logic [7:0]    x_ff;
   logic [F-1:0]  fl_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= om * pix_i;
         a_ff    <= a;
         x_ff    <= pix_i;
         fl_ff   <= fl;
      end
   end

   logic [7:0]    r1   [0:NW];
   logic [NW-1:0] n1   [0:NW];
   logic [7:0]    d1   [0:NW];
   logic [F+7:0]  p1   [0:NW];

   assign r1[0] = '0;
   assign n1[0] = prod_ff;
   assign d1[0] = a_ff;
   assign p1[0] = {x_ff, fl_ff};

   generate
      for (genvar i = 0; i < NW; i++) begin : g_div1
         htpr_div_cell #(.NW(NW), .VW(8), .PW(F + 8)) u_cell (
            .clock (clock),
            .en    (en),
            .rem_i (r1[i]),
            .num_i (n1[i]),
            .den_i (d1[i]),
            .pay_i (p1[i]),
            .rem_o (r1[i+1]),
            .num_o (n1[i+1]),
            .den_o (d1[i+1]),
            .pay_o (p1[i+1])
         );
      end
   endgenerate

   logic [7:0]    x1;
   logic [F-1:0]  fl1;
   logic [TW-1:0] lim;
   logic [NW-1:0] term;
   logic [TW-1:0] t_in;
   logic          neg_in;
   logic [7:0]    magd;

   always_comb begin
      x1     = p1[NW][F+7:F];
      fl1    = p1[NW][F-1:0];
      term   = n1[NW];
      lim    = One - {1'b0, fl1};
      t_in   = (term > NW'(lim)) ? {1'b0, fl1} : (One - term[TW-1:0]);
      neg_in = x1 < d1[NW];
      magd   = neg_in ? (d1[NW] - x1) : (x1 - d1[NW]);
   end

   logic [TW-1:0] t_ff;
   logic [NW-1:0] mag_ff;
   logic [8:0]    p2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff   <= t_in;
         mag_ff <= {magd, {F{1'b0}}};
         p2_ff  <= {d1[NW], neg_in};
      end
   end

   logic [TW-1:0] r2 [0:NW];
   logic [NW-1:0] n2 [0:NW];
   logic [TW-1:0] d2 [0:NW];
   logic [8:0]    p2 [0:NW];

   assign r2[0] = '0;
   assign n2[0] = mag_ff;
   assign d2[0] = t_ff;
   assign p2[0] = p2_ff;

   generate
      for (genvar j = 0; j < NW; j++) begin : g_div2
         htpr_div_cell #(.NW(NW), .VW(TW), .PW(9)) u_cell (
            .clock (clock),
            .en    (en),
            .rem_i (r2[j]),
            .num_i (n2[j]),
            .den_i (d2[j]),
            .pay_i (p2[j]),
            .rem_o (r2[j+1]),
            .num_o (n2[j+1]),
            .den_o (d2[j+1]),
            .pay_o (p2[j+1])
         );
      end
   endgenerate

   logic [TW:0]   twice_r;
   logic          up;
   logic [NW:0]   qr;
   logic [NW:0]   a_ext;
   logic [NW:0]   sum;
   logic [7:0]    res_in;
   logic [7:0]    res_ff;

   always_comb begin
      twice_r = {r2[NW], 1'b0};
      up      = (twice_r > {1'b0, d2[NW]}) ||
                ((twice_r == {1'b0, d2[NW]}) && n2[NW][0]);
      qr      = {1'b0, n2[NW]} + (NW + 1)'(up);
      a_ext   = (NW + 1)'(p2[NW][8:1]);
      sum     = a_ext + qr;
      if (p2[NW][0]) begin
         res_in = (a_ext >= qr) ? 8'(a_ext - qr) : 8'd0;
      end else begin
         res_in = (sum > (NW + 1)'(255)) ? 8'd255 : sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign pix_o = res_ff;

endmodule

/* rtl/haze_transmission_pixel_recover_top.sv */
// Top level of the haze transmission pixel recovery block.
// One pixel is accepted per clock and one recovered pixel leaves per clock while rsp does not
// stall long enough to fill the output buffer. In each channel a beat passes the multiply
// stage, a chain of restoring division cells (one quotient bit per cell), the transmission
// stage, a second chain, the rounding stage and the output stage. A two-deep output buffer lets
// one more beat be taken while a result waits; req_tready drops only while that buffer is full.
// Registers sit at byte address 4*i: blue, green, red airlight, blue, green, red omega, floor.
`timescale 1ns / 1ps
module haze_transmission_pixel_recover_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // in_blue, in_green, in_red
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // out_blue, out_green, out_red
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [htpr_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int Lat = 2 * (FRAC_BITS + 8) + 3;

   logic [7:0]  air_ff   [0:2];
   logic [15:0] omega_ff [0:2];
   logic [15:0] floor_ff;
   logic        wr;
   htpr_pkg::csr_index_type idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = htpr_pkg::csr_index_type'(csr_paddr[htpr_pkg::CsrAddrWidth-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            air_ff[c]   <= htpr_pkg::AirlightReset;
            omega_ff[c] <= htpr_pkg::OmegaReset;
         end
         floor_ff <= htpr_pkg::FloorReset;
      end else if (wr) begin
         unique case (idx)
            htpr_pkg::CSR_AIRLIGHT_BLUE:  air_ff[0]   <= csr_pwdata[7:0];
            htpr_pkg::CSR_AIRLIGHT_GREEN: air_ff[1]   <= csr_pwdata[7:0];
            htpr_pkg::CSR_AIRLIGHT_RED:   air_ff[2]   <= csr_pwdata[7:0];
            htpr_pkg::CSR_OMEGA_BLUE:     omega_ff[0] <= csr_pwdata[15:0];
            htpr_pkg::CSR_OMEGA_GREEN:    omega_ff[1] <= csr_pwdata[15:0];
            htpr_pkg::CSR_OMEGA_RED:      omega_ff[2] <= csr_pwdata[15:0];
            htpr_pkg::CSR_TRANS_FLOOR:    floor_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         htpr_pkg::CSR_AIRLIGHT_BLUE:  csr_prdata = {24'd0, air_ff[0]};
         htpr_pkg::CSR_AIRLIGHT_GREEN: csr_prdata = {24'd0, air_ff[1]};
         htpr_pkg::CSR_AIRLIGHT_RED:   csr_prdata = {24'd0, air_ff[2]};
         htpr_pkg::CSR_OMEGA_BLUE:     csr_prdata = {16'd0, omega_ff[0]};
         htpr_pkg::CSR_OMEGA_GREEN:    csr_prdata = {16'd0, omega_ff[1]};
         htpr_pkg::CSR_OMEGA_RED:      csr_prdata = {16'd0, omega_ff[2]};
         htpr_pkg::CSR_TRANS_FLOOR:    csr_prdata = {16'd0, floor_ff};
         default:                      csr_prdata = 32'd0;
      endcase
   end

   logic        en;
   logic [23:0] pipe_data;
   logic [Lat-1:0] vld_ff;
   logic [Lat-1:0] vld_in;

   generate
      for (genvar c = 0; c < 3; c++) begin : g_chan
         htpr_pkg::chan_cfg_type cfg;
         assign cfg.airlight    = air_ff[c];
         assign cfg.omega       = omega_ff[c];
         assign cfg.trans_floor = floor_ff;
         htpr_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
            .clock (clock),
            .en    (en),
            .cfg   (cfg),
            .pix_i (req_tdata[8*c +: 8]),
            .pix_o (pipe_data[8*c +: 8])
         );
      end
   endgenerate

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [23:0] out_data_ff;
   logic [23:0] out_data_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   logic [23:0] skid_data_ff;
   logic [23:0] skid_data_in;
   logic        take;
   logic        pipe_out;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign vld_in     = {vld_ff[Lat-2:0], req_tvalid && req_tready};
   assign take       = out_valid_ff && rsp_tready;
   assign pipe_out   = vld_ff[Lat-1] && en;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = pipe_out;
            out_data_in  = pipe_data;
         end
      end else if (pipe_out) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= vld_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* rtl/htpr_checker.sv */
// Port-level checker of the haze transmission pixel recovery block, bound to the top level.
`timescale 1ns / 1ps
module htpr_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp beat dropped while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("req stalled without a stalled rsp beat");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with no rsp beat pending");

   a_buffer_drain: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> rsp_tvalid)
      else $error("buffered rsp beat lost");

endmodule

bind haze_transmission_pixel_recover_top htpr_checker u_htpr_checker (.*);

/* tb/haze_recover_checker.sv */
// Checker that predicts recovered pixels from observed input beats and compares them.
`timescale 1ns / 1ps
module haze_recover_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [htpr_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_count
);

   localparam int FracBits = 16;

   logic [15:0] shadow_reg [0:6];
   logic [23:0] want_mem [0:1023];
   int          wr_cnt = 0;
   int          rd_cnt = 0;

   assign pending_count = wr_cnt - rd_cnt;

   function automatic logic [7:0] recover_level(logic [7:0] level, logic [7:0] air_reg,
                                                logic [15:0] omega_reg, logic [15:0] floor_reg);
      longint one, air, x, om, fl, t, d, mag, q, r, res;
      bit neg;
      one = longint'(1) << FracBits;
      air = air_reg;
      x = level;
      om = omega_reg;
      fl = floor_reg;
      if (air < 1) air = 1;
      if (fl < 1) fl = 1;
      t = one - (om * x) / air;
      if (t < fl) t = fl;
      d = x - air;
      neg = d < 0;
      mag = (neg ? -d : d) * one;
      q = mag / t;
      r = mag % t;
      if (2 * r > t || (2 * r == t && q[0])) q = q + 1;
      res = air + (neg ? -q : q);
      if (res < 0) res = 0;
      if (res > 255) res = 255;
      return res[7:0];
   endfunction

   function automatic logic [23:0] recover_pixel(logic [23:0] pix);
      logic [23:0] out;
      for (int c = 0; c < 3; c++)
         out[8*c +: 8] = recover_level(pix[8*c +: 8], shadow_reg[c][7:0], shadow_reg[3+c],
                                       shadow_reg[htpr_pkg::CSR_TRANS_FLOOR]);
      return out;
   endfunction

   always @(posedge clock) begin
      logic [23:0] want;
      if (reset) begin
         fail_count <= 0;
         shadow_reg[htpr_pkg::CSR_AIRLIGHT_BLUE]  <= htpr_pkg::AirlightReset;
         shadow_reg[htpr_pkg::CSR_AIRLIGHT_GREEN] <= htpr_pkg::AirlightReset;
         shadow_reg[htpr_pkg::CSR_AIRLIGHT_RED]   <= htpr_pkg::AirlightReset;
         shadow_reg[htpr_pkg::CSR_OMEGA_BLUE]     <= htpr_pkg::OmegaReset;
         shadow_reg[htpr_pkg::CSR_OMEGA_GREEN]    <= htpr_pkg::OmegaReset;
         shadow_reg[htpr_pkg::CSR_OMEGA_RED]      <= htpr_pkg::OmegaReset;
         shadow_reg[htpr_pkg::CSR_TRANS_FLOOR]    <= htpr_pkg::FloorReset;
         wr_cnt <= 0;
         rd_cnt <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[4:2] < htpr_pkg::CSR_UNUSED) begin
            if (csr_paddr[4:2] < htpr_pkg::CSR_OMEGA_BLUE)
               shadow_reg[csr_paddr[4:2]] <= {8'd0, csr_pwdata[7:0]};
            else
               shadow_reg[csr_paddr[4:2]] <= csr_pwdata[15:0];
         end
         if (req_tvalid && req_tready) begin
            want_mem[wr_cnt % 1024] <= recover_pixel(req_tdata);
            wr_cnt <= wr_cnt + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (wr_cnt == rd_cnt) begin
               $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = want_mem[rd_cnt % 1024];
               rd_cnt <= rd_cnt + 1;
               if (want !== rsp_tdata) begin
                  $display("%0t: mismatch, expected %h, actual %h", $time, want, rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* tb/tb_top.sv */
// Top of the haze recovery testbench: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module tb_top;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [htpr_pkg::CsrAddrWidth-1:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_count;

   always #5 clock = ~clock;

   haze_transmission_pixel_recover_top i_dut (.*);

   haze_recover_checker i_checker (.*);

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = $urandom_range(0, 9);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic write_reg(htpr_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_pixel(logic [23:0] pix, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_all(logic [7:0] a, logic [15:0] om, logic [15:0] fl);
      write_reg(htpr_pkg::CSR_AIRLIGHT_BLUE, a);
      write_reg(htpr_pkg::CSR_AIRLIGHT_GREEN, a);
      write_reg(htpr_pkg::CSR_AIRLIGHT_RED, a);
      write_reg(htpr_pkg::CSR_OMEGA_BLUE, om);
      write_reg(htpr_pkg::CSR_OMEGA_GREEN, om);
      write_reg(htpr_pkg::CSR_OMEGA_RED, om);
      write_reg(htpr_pkg::CSR_TRANS_FLOOR, fl);
   endtask

   task automatic random_regs();
      for (int i = 0; i < 3; i++)
         write_reg(htpr_pkg::csr_index_type'(i), $urandom());
      for (int i = 3; i < 7; i++)
         write_reg(htpr_pkg::csr_index_type'(i), $urandom());
      write_reg(htpr_pkg::CSR_UNUSED, $urandom());
   endtask

   initial begin
      logic [23:0] corner [0:7];
      corner = '{24'h000000, 24'hffffff, 24'h00ff00, 24'hff00ff,
                 24'h010203, 24'hdcdcdc, 24'h7f80fe, 24'h55aa33};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int i = 0; i < 8; i++) send_pixel(corner[i], i > 4);
      drain();
      set_all(8'd255, 16'hffff, 16'h0001);
      for (int i = 0; i < 8; i++) send_pixel(corner[i], 1);
      drain();
      set_all(8'd0, 16'h0000, 16'hffff);
      for (int i = 0; i < 6; i++) send_pixel(corner[i], 0);
      drain();
      set_all(8'd1, 16'h8000, 16'h0000);
      write_reg(htpr_pkg::CSR_AIRLIGHT_GREEN, 32'hffffff80);
      for (int i = 0; i < 3; i++) send_pixel(corner[i], 0);
      drain();
      for (int phase = 0; phase < 15; phase++) begin
         random_regs();
         for (int i = 0; i < 50; i++) send_pixel(24'($urandom()), phase % 4 == 0);
         drain();
      end
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
